/* src/cpuu_pkg.sv */
`timescale 1ns / 1ps

package cpuu_pkg;

  localparam int unsigned CTR_W_DEF       = 64;
  localparam int unsigned TICK_W          = 64;
  localparam int unsigned NUM_CTR         = 10;
  localparam int unsigned CTR_IDX_W       = $clog2(NUM_CTR);
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned CPU_W           = 8;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  // counter order inside the block
  localparam logic [CTR_IDX_W-1:0] CTR_USER       = 4'd0;
  localparam logic [CTR_IDX_W-1:0] CTR_NICE       = 4'd1;
  localparam logic [CTR_IDX_W-1:0] CTR_SYSTEM     = 4'd2;
  localparam logic [CTR_IDX_W-1:0] CTR_IDLE       = 4'd3;
  localparam logic [CTR_IDX_W-1:0] CTR_IOWAIT     = 4'd4;
  localparam logic [CTR_IDX_W-1:0] CTR_IRQ        = 4'd5;
  localparam logic [CTR_IDX_W-1:0] CTR_SOFTIRQ    = 4'd6;
  localparam logic [CTR_IDX_W-1:0] CTR_STEAL      = 4'd7;
  localparam logic [CTR_IDX_W-1:0] CTR_GUEST      = 4'd8;
  localparam logic [CTR_IDX_W-1:0] CTR_GUEST_NICE = 4'd9;
  localparam logic [CTR_IDX_W-1:0] CTR_LAST       = CTR_IDX_W'(NUM_CTR - 1);

  // register indexes
  localparam logic REG_ALL_FIELDS_ENABLE = 1'b0;

  typedef logic [CTR_IDX_W-1:0] ctr_idx_t;

  typedef struct packed {
    logic signed [CPU_W-1:0] cpu_id;
    logic                    first_sample;
    logic [TICK_W-1:0]       user_ticks;
    logic [TICK_W-1:0]       nice_ticks;
    logic [TICK_W-1:0]       system_ticks;
    logic [TICK_W-1:0]       idle_ticks;
    logic [TICK_W-1:0]       iowait_ticks;
    logic [TICK_W-1:0]       irq_ticks;
    logic [TICK_W-1:0]       softirq_ticks;
    logic [TICK_W-1:0]       steal_ticks;
    logic [TICK_W-1:0]       guest_ticks;
    logic [TICK_W-1:0]       guest_nice_ticks;
  } in_item_t;

  typedef struct packed {
    logic signed [CPU_W-1:0] cpu_out;
    logic [PCT_W-1:0]        user_pct;
    logic [PCT_W-1:0]        system_pct;
    logic [PCT_W-1:0]        idle_pct;
    logic [PCT_W-1:0]        nice_pct;
    logic [PCT_W-1:0]        iowait_pct;
    logic [PCT_W-1:0]        irq_pct;
    logic [PCT_W-1:0]        softirq_pct;
    logic [PCT_W-1:0]        steal_pct;
    logic [PCT_W-1:0]        guest_pct;
    logic [PCT_W-1:0]        guest_nice_pct;
  } out_item_t;

  // user, system and idle are reported whatever the enable says
  function automatic logic ctr_always(input ctr_idx_t k);
    return (k == CTR_USER) || (k == CTR_SYSTEM) || (k == CTR_IDLE);
  endfunction

  function automatic int unsigned entry_width(input int unsigned cw);
    return CPU_W + 2 + cw * (NUM_CTR + 1);
  endfunction

endpackage

/* src/cpuu_queue.sv */
`timescale 1ns / 1ps

module cpuu_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* src/cpuu_front.sv */
`timescale 1ns / 1ps

module cpuu_front #(
  parameter int unsigned CW      = cpuu_pkg::CTR_W_DEF,
  parameter int unsigned ENTRY_W = cpuu_pkg::entry_width(cpuu_pkg::CTR_W_DEF)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  cpuu_pkg::in_item_t item,
  input  logic               enable,
  output logic               q_push,
  input  logic               q_full,
  output logic [ENTRY_W-1:0] q_data
);
  import cpuu_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_SUM, F_PUSH} fstate_t;

  fstate_t                         state;
  logic [NUM_CTR-1:0][CW-1:0]      prev;
  logic [NUM_CTR-1:0][CW-1:0]      delta;
  logic [NUM_CTR-1:0][CW-1:0]      cur;
  logic [CW-1:0]                   total;
  ctr_idx_t                        idx;
  logic signed [CPU_W-1:0]         cpu;
  logic                            first;
  logic                            en;
  logic                            accept;

  assign cur[CTR_USER]       = item.user_ticks[CW-1:0];
  assign cur[CTR_NICE]       = item.nice_ticks[CW-1:0];
  assign cur[CTR_SYSTEM]     = item.system_ticks[CW-1:0];
  assign cur[CTR_IDLE]       = item.idle_ticks[CW-1:0];
  assign cur[CTR_IOWAIT]     = item.iowait_ticks[CW-1:0];
  assign cur[CTR_IRQ]        = item.irq_ticks[CW-1:0];
  assign cur[CTR_SOFTIRQ]    = item.softirq_ticks[CW-1:0];
  assign cur[CTR_STEAL]      = item.steal_ticks[CW-1:0];
  assign cur[CTR_GUEST]      = item.guest_ticks[CW-1:0];
  assign cur[CTR_GUEST_NICE] = item.guest_nice_ticks[CW-1:0];

  assign full   = rst || (state != F_IDLE);
  assign accept = push && !full;
  assign q_push = (state == F_PUSH);
  assign q_data = {cpu, first, en, total, delta};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      prev  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            for (int k = 0; k < NUM_CTR; k++) begin
              delta[k] <= cur[k] - prev[k];
            end
            prev  <= cur;
            cpu   <= item.cpu_id;
            first <= item.first_sample;
            en    <= enable;
            total <= '0;
            idx   <= '0;
            state <= F_SUM;
          end
        end
        F_SUM: begin
          // one counter a cycle into the running total, wraps at the counter width
          total <= total + delta[idx];
          if (idx == CTR_LAST) begin
            state <= F_PUSH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

/* src/cpuu_back.sv */
`timescale 1ns / 1ps

module cpuu_back #(
  parameter int unsigned CW      = cpuu_pkg::CTR_W_DEF,
  parameter int unsigned ENTRY_W = cpuu_pkg::entry_width(cpuu_pkg::CTR_W_DEF)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  logic [ENTRY_W-1:0]  q_data,
  output logic                q_pop,
  output cpuu_pkg::out_item_t result,
  output logic                empty,
  input  logic                pop
);
  import cpuu_pkg::*;

  localparam int unsigned NW = CW + PCT_W;

  typedef enum logic [1:0] {B_IDLE, B_LOAD, B_DIV, B_DONE} bstate_t;

  bstate_t                         state;
  logic signed [CPU_W-1:0]         e_cpu;
  logic                            e_first;
  logic                            e_en;
  logic [CW-1:0]                   e_total;
  logic [NUM_CTR-1:0][CW-1:0]      e_delta;

  logic signed [CPU_W-1:0]         cpu;
  logic                            skip;
  logic                            en;
  logic [CW-1:0]                   tot;
  logic [NUM_CTR-1:0][CW-1:0]      dlt;
  logic [NUM_CTR-1:0][PCT_W-1:0]   pct;
  ctr_idx_t                        k;
  logic [2:0]                      bit_i;
  logic [NW-1:0]                   num;
  logic [PCT_W-1:0]                quo;
  logic                            out_valid;

  logic [CW-1:0]                   d;
  logic                            need;
  logic [NW-1:0]                   d_ext;
  logic [NW-1:0]                   d_x100;
  logic [NW-1:0]                   t_sh;
  logic                            ge;
  logic [PCT_W-1:0]                quo_next;

  assign {e_cpu, e_first, e_en, e_total, e_delta} = q_data;

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign empty = rst || !out_valid;

  always_comb begin
    d        = dlt[k];
    need     = !skip && (ctr_always(k) || en);
    d_ext    = NW'(d);
    // times 100 as 64 + 32 + 4
    d_x100   = (d_ext << 6) + (d_ext << 5) + (d_ext << 2);
    t_sh     = NW'(tot) << bit_i;
    ge       = (num >= t_sh);
    quo_next = quo;
    if (ge) begin
      quo_next[bit_i] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
      bit_i     <= '0;
    end else begin
      if (pop && out_valid && state != B_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cpu   <= e_cpu;
            skip  <= e_first || (e_total == '0);
            en    <= e_en;
            tot   <= e_total;
            dlt   <= e_delta;
            k     <= '0;
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          if (!need || d >= tot) begin
            // delta at or above the total (all ticks in one counter, or a wrapped counter): clamp
            pct[k] <= need ? PCT_FULL : '0;
            if (k == CTR_LAST) begin
              state <= B_DONE;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            num   <= d_x100;
            quo   <= '0;
            bit_i <= 3'(PCT_W - 1);
            state <= B_DIV;
          end
        end
        B_DIV: begin
          // restoring division, one quotient bit a cycle; quotient stays below 100
          if (ge) begin
            num <= num - t_sh;
          end
          quo <= quo_next;
          if (bit_i == '0) begin
            pct[k] <= quo_next;
            if (k == CTR_LAST) begin
              state <= B_DONE;
            end else begin
              k     <= k + 1'b1;
              state <= B_LOAD;
            end
          end else begin
            bit_i <= bit_i - 1'b1;
          end
        end
        B_DONE: begin
          if (!out_valid || pop) begin
            result.cpu_out        <= cpu;
            result.user_pct       <= pct[CTR_USER];
            result.system_pct     <= pct[CTR_SYSTEM];
            result.idle_pct       <= pct[CTR_IDLE];
            result.nice_pct       <= pct[CTR_NICE];
            result.iowait_pct     <= pct[CTR_IOWAIT];
            result.irq_pct        <= pct[CTR_IRQ];
            result.softirq_pct    <= pct[CTR_SOFTIRQ];
            result.steal_pct      <= pct[CTR_STEAL];
            result.guest_pct      <= pct[CTR_GUEST];
            result.guest_nice_pct <= pct[CTR_GUEST_NICE];
            out_valid             <= 1'b1;
            state                 <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

/* src/cpu_usage_percent_from_counters.sv */
`timescale 1ns / 1ps
// cpu usage percentages from snapshots of ten cumulative tick counters
//
// input queue side: drive item and push; a beat is taken when push is high and
// full is low. result queue side: result holds the oldest result while empty
// is low; pop takes it. one result per input beat, in order.
// apb port: register 0 (byte address 0) is all_fields_enable, reset 1; write
// it only while no item is in flight.
//
// a front stage takes the snapshot, forms the deltas against the stored
// previous snapshot and sums them, one counter a cycle; a 2-entry queue
// feeds the back stage, which works out the ten percentages with one
// shared restoring divider, one counter after the other. the front can
// take the next snapshot while the back stage still divides the last one,
// until the queue fills.
//
// reset clears the stored snapshot to zero, empties the queue and the result
// register, and sets the enable. when pop stays low the finished result waits
// in the result register, the back stage holds its next result, the queue
// fills and full then rises to stall the sender.
module cpu_usage_percent_from_counters #(
  parameter int unsigned COUNTER_WIDTH = cpuu_pkg::CTR_W_DEF,
  parameter int unsigned QUEUE_DEPTH   = cpuu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  cpuu_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output cpuu_pkg::out_item_t result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cpuu_pkg::*;

  localparam int unsigned ENTRY_W = entry_width(COUNTER_WIDTH);

  logic               all_fields_enable;
  logic               cfg_wr;
  logic               q_push;
  logic               q_full;
  logic [ENTRY_W-1:0] q_din;
  logic               q_pop;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_dout;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_ALL_FIELDS_ENABLE) ? {31'd0, all_fields_enable} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      all_fields_enable <= 1'b1;
    end else if (cfg_wr && paddr[2] == REG_ALL_FIELDS_ENABLE) begin
      all_fields_enable <= pwdata[0];
    end
  end

  cpuu_front #(
    .CW      (COUNTER_WIDTH),
    .ENTRY_W (ENTRY_W)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .enable (all_fields_enable),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_din)
  );

  cpuu_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  cpuu_back #(
    .CW      (COUNTER_WIDTH),
    .ENTRY_W (ENTRY_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_dout),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

/* src/cpuu_checker.sv */
`timescale 1ns / 1ps

module cpuu_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input cpuu_pkg::out_item_t result,
  input logic                psel,
  input logic                penable,
  input logic                pwrite,
  input logic [2:0]          paddr,
  input logic [31:0]         pwdata,
  input logic [31:0]         prdata
);
  import cpuu_pkg::*;

  // nothing is waiting on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result present after reset");

  // the front works on one snapshot at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("front took a beat while busy");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.user_pct <= PCT_FULL && result.system_pct <= PCT_FULL &&
                result.idle_pct <= PCT_FULL && result.nice_pct <= PCT_FULL))
    else $error("percentage above 100");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[2] == REG_ALL_FIELDS_ENABLE) |=>
      (paddr[2] != REG_ALL_FIELDS_ENABLE || prdata[0] == $past(pwdata[0])))
    else $error("enable register did not take the write");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind cpu_usage_percent_from_counters cpuu_checker u_cpuu_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .result  (result),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);
